### rtl/core/sv39m_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39m_pkg: shared types and constants of the Sv39 page range mapper
// Status codes, field widths, the valid flag and the table entry builder.
// ----------------------------------------------------------------------------
package sv39m_pkg;

    localparam int PPN_W     = 44;
    localparam int VA_W      = 39;
    localparam int PA_W      = 56;
    localparam int ENTRY_W   = 64;
    localparam int VPN_W     = 9;
    localparam int PAGE_SH   = 12;
    localparam int PERM_W    = 5;
    localparam int PG_CNT_W  = 13;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_ZERO   = 3'd1,
        ST_LIMIT  = 3'd2,
        ST_POOL   = 3'd3,
        ST_MAPPED = 3'd4
    } t_status;

    localparam logic [PERM_W-1:0] PTE_V = 5'b00001;

    // Builds a table entry from a page number and flag bits.
    function automatic logic [ENTRY_W-1:0] make_entry(input logic [PPN_W-1:0] ppn,
                                                     input logic [PERM_W-1:0] flags);
        make_entry = {10'd0, ppn, 5'd0, flags};
    endfunction

endpackage

### rtl/core/sv39m_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39m_ram: generic single port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module sv39m_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/core/sv39_page_range_mapper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39_page_range_mapper_top: Sv39 table walker that maps a virtual range
// Walks a three-level table in an internal page pool and writes leaf entries.
// ----------------------------------------------------------------------------
// Usage. A request item is taken when i_start is high while o_busy is low.
// The block then maps the range page by page, from the page holding the
// start address to the page holding the last byte. For each page a small
// sequencer drives the single table memory port: a setup cycle, then a read
// of the level-2 entry, the level-1 entry and the leaf, each followed by a
// wait for the registered read data and an evaluation cycle. Any write of a
// fresh table or a leaf overlaps the next step. One status item is then
// shown on o_status, marked by o_done, which is high for a single cycle;
// the receiver cannot stall it, and o_busy falls with it. The base register
// is written through i_cfg_we and i_cfg_data; the user must write it only
// while idle, as the block itself does not enforce this. After reset the
// pool is cleared by a sweep over every entry, one entry per cycle, during
// which o_busy stays high and no item is taken. Failures part way leave
// the pages already mapped in place.
// ----------------------------------------------------------------------------
module sv39_page_range_mapper_top
    import sv39m_pkg::*;
#(
    parameter int POOL_PAGES    = 16,
    parameter int VA_LIMIT_BITS = 38
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  logic [VA_W-1:0] i_virt_addr,
    input  logic [PA_W-1:0] i_phys_addr,
    input  logic [VA_W-1:0] i_byte_count,
    input  logic            i_perm_read,
    input  logic            i_perm_write,
    input  logic            i_perm_exec,
    input  logic            i_perm_user,
    input  logic            i_cfg_we,
    input  logic [PPN_W-1:0] i_cfg_data,
    output logic            o_done,
    output logic [2:0]      o_status
);
    localparam int DEPTH = POOL_PAGES * 512;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(POOL_PAGES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SETUP, S_READ, S_WAIT, S_EVAL, S_DONE
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_addr;
    logic             r_we;
    logic [ENTRY_W-1:0] r_wdata;
    logic [ENTRY_W-1:0] w_rdata;
    logic [PPN_W-1:0] r_base;
    // One bit above the virtual page number, so that a range running off
    // the top of the address space is still seen beyond the limit.
    logic [VA_W-12:0] r_vpn;
    logic [VA_W-12:0] r_last;
    logic [PPN_W-1:0] r_ppn;
    logic [PERM_W-1:0] r_perm;
    logic [1:0]       r_level;
    logic [PW-1:0]    r_page;
    logic [PG_CNT_W-1:0] r_used;
    logic [2:0]       r_status;
    logic             r_done;

    sv39m_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_addr (r_addr),
        .i_wdata(r_wdata),
        .o_rdata(w_rdata)
    );

    // Index of the entry for the current page at the current level.
    logic [VPN_W-1:0] w_vpn_part;
    always_comb begin
        unique case (r_level)
            2'd2:    w_vpn_part = r_vpn[26:18];
            2'd1:    w_vpn_part = r_vpn[17:9];
            default: w_vpn_part = r_vpn[8:0];
        endcase
    end

    // Last byte of the range, computed from the inputs at acceptance.
    logic [VA_W:0]    w_end;
    assign w_end = {1'b0, i_virt_addr} + {1'b0, i_byte_count} - (VA_W+1)'(1);

    logic [PPN_W-1:0] w_idx;
    assign w_idx = w_rdata[53:10] - r_base;

    logic w_over;
    assign w_over = ({r_vpn, 12'd0} >> VA_LIMIT_BITS) != '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_we     <= 1'b1;
            r_wdata  <= '0;
            r_base   <= PPN_W'(524288);
            r_used   <= PG_CNT_W'(1);
            r_done   <= 1'b0;
            r_status <= ST_OK;
            r_level  <= 2'd2;
            r_page   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == AW'(DEPTH - 1)) begin
                        r_we    <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    r_we <= 1'b0;
                    if (i_start) begin
                        r_vpn  <= {1'b0, i_virt_addr[VA_W-1:12]};
                        r_last <= w_end[VA_W:12];
                        r_ppn  <= i_phys_addr[55:12];
                        r_perm <= {i_perm_user, i_perm_exec, i_perm_write,
                                   i_perm_read, 1'b1};
                        if (i_byte_count == '0) begin
                            r_status <= ST_ZERO;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_we    <= 1'b0;
                    r_level <= 2'd2;
                    r_page  <= '0;
                    if (w_over) begin
                        r_status <= ST_LIMIT;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_we    <= 1'b0;
                    r_addr  <= {r_page, w_vpn_part};
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_level == 2'd0) begin
                        if (w_rdata[0]) begin
                            r_status <= ST_MAPPED;
                            r_state  <= S_DONE;
                        end else begin
                            r_we    <= 1'b1;
                            r_wdata <= make_entry(r_ppn, r_perm);
                            if (r_vpn == r_last) begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end else begin
                                r_vpn   <= r_vpn + (VA_W-11)'(1);
                                r_ppn   <= r_ppn + PPN_W'(1);
                                r_state <= S_SETUP;
                            end
                        end
                    end else if (w_rdata[0]) begin
                        if (w_idx >= PPN_W'(r_used)) begin
                            r_status <= ST_POOL;
                            r_state  <= S_DONE;
                        end else begin
                            r_page  <= w_idx[PW-1:0];
                            r_level <= r_level - 2'd1;
                            r_state <= S_READ;
                        end
                    end else if (r_used >= PG_CNT_W'(POOL_PAGES)) begin
                        r_status <= ST_POOL;
                        r_state  <= S_DONE;
                    end else begin
                        r_we    <= 1'b1;
                        r_wdata <= make_entry(r_base + PPN_W'(r_used), PTE_V);
                        r_page  <= r_used[PW-1:0];
                        r_used  <= r_used + PG_CNT_W'(1);
                        r_level <= r_level - 2'd1;
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    r_we    <= 1'b0;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Busy drops in the cycle the status is shown.
    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_status = r_status;
endmodule

### rtl/core/sv39m_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sv39m_checker: port level checks of the page range mapper
// Watches the command and status ports of the top level.
// ----------------------------------------------------------------------------
module sv39m_checker
    import sv39m_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [2:0] o_status
);
    // A status item only appears when the block goes idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("done while busy");

    // An accepted item makes the block busy next cycle.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("not busy after start");

    // Status codes stay within the defined set.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= 3'd4)) else $error("bad status");

    // Done is a single cycle strobe.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done longer than a cycle");
endmodule

bind sv39_page_range_mapper_top sv39m_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_done  (o_done),
    .o_status(o_status)
);
